>>> sv/first_fit_region_allocator_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> sv/ffra_pkg.sv
package ffra_pkg;

    // Default sizing of the free table.
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_ADDRESS_BITS  = 16;

    // Fixed field widths.
    localparam int ADDR_IN_W = 16;
    localparam int LEN_W     = 17;
    localparam int STATUS_W  = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Free table contents after reset.
    localparam int RST_START_A  = 14;
    localparam int RST_LENGTH_A = 12;
    localparam int RST_START_B  = 32;
    localparam int RST_LENGTH_B = 96;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_EXE
    } state_t;

    // Table update applied by the cells.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SHRINK,
        ACT_REMOVE,
        ACT_GROW_PREV,
        ACT_GROW_NEXT,
        ACT_JOIN,
        ACT_INSERT
    } act_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic exe_en;
        act_t act;
    } ctl_t;

    // Compare results registered in each cell.
    typedef struct packed {
        logic fits;
        logic eq;
        logic gt;
        logic next_eq;
        logic end_eq;
    } flags_t;

    // Length sum that saturates at the largest length.
    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    endfunction

    function automatic int reset_start(input int idx);
        if (idx == 0) return RST_START_A;
        if (idx == 1) return RST_START_B;
        return 0;
    endfunction

    function automatic int reset_length(input int idx);
        if (idx == 0) return RST_LENGTH_A;
        if (idx == 1) return RST_LENGTH_B;
        return 0;
    endfunction

endpackage

>>> sv/ffra_pick.sv
module ffra_pick #(
    parameter int W = ffra_pkg::DEF_TABLE_ENTRIES
) (
    input  logic [W-1:0] req,
    output logic [W-1:0] hot,
    output logic [W-1:0] ge
);
    logic [W-1:0] neg;

    // Two's complement isolates the lowest set bit and fills everything above it.
    assign neg = ~req + W'(1);
    assign hot = req & neg;
    assign ge  = req | neg;

endmodule

>>> sv/ffra_cell.sv
module ffra_cell #(
    parameter int   ADDR_W       = ffra_pkg::DEF_ADDRESS_BITS,
    parameter int   RESET_START  = 0,
    parameter int   RESET_LENGTH = 0,
    parameter bit   RESET_VALID  = 1'b0,
    localparam int  SUM_W = ((ADDR_W > ffra_pkg::LEN_W) ? ADDR_W : ffra_pkg::LEN_W) + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ffra_pkg::ctl_t              ctl,
    input  logic                        tgt,
    input  logic                        span,
    input  logic [ADDR_W-1:0]           req_addr,
    input  logic [ffra_pkg::LEN_W-1:0]  req_len,
    input  logic [SUM_W-1:0]            req_end,
    input  logic [ADDR_W-1:0]           left_start,
    input  logic [ffra_pkg::LEN_W-1:0]  left_len,
    input  logic                        left_valid,
    input  logic [ADDR_W-1:0]           right_start,
    input  logic [ffra_pkg::LEN_W-1:0]  right_len,
    input  logic                        right_valid,
    output logic [ADDR_W-1:0]           start_o,
    output logic [ffra_pkg::LEN_W-1:0]  len_o,
    output logic                        valid_o,
    output ffra_pkg::flags_t            flags_o
);
    import ffra_pkg::*;

    logic [ADDR_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              valid_reg, valid_next;
    flags_t            flags_reg, flags_next;
    logic [LEN_W-1:0]  len_plus_reg, len_plus_next;

    // Compare this entry against the request.
    always_comb begin
        flags_next.fits    = valid_reg && (len_reg >= req_len);
        flags_next.eq      = valid_reg && (len_reg == req_len);
        flags_next.gt      = valid_reg && (start_reg > req_addr);
        flags_next.next_eq = valid_reg && (SUM_W'(start_reg) == req_end);
        flags_next.end_eq  = valid_reg &&
                             ((SUM_W'(start_reg) + SUM_W'(len_reg)) == SUM_W'(req_addr));
        len_plus_next      = sat_add(len_reg, req_len);
    end

    // Apply the chosen update: the target entry changes, the entries in the span move.
    always_comb begin
        start_next = start_reg;
        len_next   = len_reg;
        valid_next = valid_reg;
        if (ctl.exe_en) begin
            if (tgt) begin
                unique case (ctl.act)
                    ACT_SHRINK: begin
                        start_next = ADDR_W'(SUM_W'(start_reg) + SUM_W'(req_len));
                        len_next   = len_reg - req_len;
                    end
                    ACT_REMOVE: begin
                        start_next = right_start;
                        len_next   = right_len;
                        valid_next = right_valid;
                    end
                    ACT_GROW_PREV: begin
                        len_next = len_plus_reg;
                    end
                    ACT_GROW_NEXT: begin
                        start_next = req_addr;
                        len_next   = len_plus_reg;
                    end
                    ACT_JOIN: begin
                        len_next = sat_add(len_plus_reg, right_len);
                    end
                    ACT_INSERT: begin
                        start_next = req_addr;
                        len_next   = req_len;
                        valid_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if (span) begin
                unique case (ctl.act)
                    ACT_REMOVE, ACT_JOIN: begin
                        start_next = right_start;
                        len_next   = right_len;
                        valid_next = right_valid;
                    end
                    ACT_INSERT: begin
                        start_next = left_start;
                        len_next   = left_len;
                        valid_next = left_valid;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Entry state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= ADDR_W'(RESET_START);
            len_reg   <= LEN_W'(RESET_LENGTH);
            valid_reg <= RESET_VALID;
        end else begin
            start_reg <= start_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

    // Compare results, held from the compare cycle to the update cycle.
    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            flags_reg    <= flags_next;
            len_plus_reg <= len_plus_next;
        end
    end

    assign start_o = start_reg;
    assign len_o   = len_reg;
    assign valid_o = valid_reg;
    assign flags_o = flags_reg;

endmodule

>>> sv/first_fit_region_allocator_core.sv
// Each accepted item passes through the compare, select and update states, and the
// result is registered at the update; the row of table cells works on one item at a time,
// compares in parallel, then shifts at most one place in the update state.
// A result held on the output stalls the update cycle of the next item until it is taken.
// Reset (synchronous, active low) loads the table with regions 14/12 and 32/96 and
// empties the output register.
module first_fit_region_allocator_core #(
    parameter int TABLE_ENTRIES = ffra_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = ffra_pkg::DEF_ADDRESS_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [ffra_pkg::ADDR_IN_W-1:0]  s_address,
    input  logic [ffra_pkg::LEN_W-1:0]      s_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ffra_pkg::STATUS_W-1:0]   m_status,
    output logic [ffra_pkg::ADDR_IN_W-1:0]  m_granted_address
);
    import ffra_pkg::*;

    localparam int N      = TABLE_ENTRIES;
    localparam int ADDR_W = ADDRESS_BITS;
    localparam int SUM_W  = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;

    state_t state_reg, state_next;

    logic                cmd_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [SUM_W-1:0]    req_end;

    act_t                act_reg, act_next;
    logic [N-1:0]        tgt_reg, tgt_next;
    logic [N-1:0]        span_reg, span_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_IN_W-1:0] m_granted_reg;

    ctl_t                ctl;
    logic                load_req;
    logic                load_sel;
    logic                load_out;

    logic [ADDR_W-1:0]   cell_start [N];
    logic [LEN_W-1:0]    cell_len   [N];
    logic [N-1:0]        cell_valid;
    flags_t              cell_flags [N];

    logic [N-1:0]        fits_vec, eq_vec, next_vec, end_vec, pos_req;
    logic [N-1:0]        fit_hot, fit_ge, p_hot, p_ge, pm1_hot;
    logic                p_none;
    logic                merge_next, merge_prev, fit_exact;
    logic [ADDR_W-1:0]   granted_any;

    assign req_end = SUM_W'(addr_reg) + SUM_W'(len_reg);

    // Row of table cells; each sees its two neighbors.
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        logic [ADDR_W-1:0] lft_start, rgt_start;
        logic [LEN_W-1:0]  lft_len, rgt_len;
        logic              lft_valid, rgt_valid;

        if (gi == 0) begin : g_first
            assign lft_start = '0;
            assign lft_len   = '0;
            assign lft_valid = 1'b0;
        end else begin : g_inner_l
            assign lft_start = cell_start[gi-1];
            assign lft_len   = cell_len[gi-1];
            assign lft_valid = cell_valid[gi-1];
        end

        if (gi == N - 1) begin : g_last
            assign rgt_start = '0;
            assign rgt_len   = '0;
            assign rgt_valid = 1'b0;
        end else begin : g_inner_r
            assign rgt_start = cell_start[gi+1];
            assign rgt_len   = cell_len[gi+1];
            assign rgt_valid = cell_valid[gi+1];
        end

        ffra_cell #(
            .ADDR_W       (ADDR_W),
            .RESET_START  (reset_start(gi)),
            .RESET_LENGTH (reset_length(gi)),
            .RESET_VALID  (gi < 2)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .tgt         (tgt_reg[gi]),
            .span        (span_reg[gi]),
            .req_addr    (addr_reg),
            .req_len     (len_reg),
            .req_end     (req_end),
            .left_start  (lft_start),
            .left_len    (lft_len),
            .left_valid  (lft_valid),
            .right_start (rgt_start),
            .right_len   (rgt_len),
            .right_valid (rgt_valid),
            .start_o     (cell_start[gi]),
            .len_o       (cell_len[gi]),
            .valid_o     (cell_valid[gi]),
            .flags_o     (cell_flags[gi])
        );

        assign fits_vec[gi] = cell_flags[gi].fits;
        assign eq_vec[gi]   = cell_flags[gi].eq;
        assign next_vec[gi] = cell_flags[gi].next_eq;
        assign end_vec[gi]  = cell_flags[gi].end_eq;
        assign pos_req[gi]  = cell_flags[gi].gt | ~cell_valid[gi];
    end

    // First region that is long enough.
    ffra_pick #(.W(N)) u_pick_fit (
        .req (fits_vec),
        .hot (fit_hot),
        .ge  (fit_ge)
    );

    // Insert position: first entry above the freed address, or the first empty slot.
    ffra_pick #(.W(N)) u_pick_pos (
        .req (pos_req),
        .hot (p_hot),
        .ge  (p_ge)
    );

    assign p_none     = ~|pos_req;
    assign pm1_hot    = {p_none, p_hot[N-1:1]};
    assign merge_next = |(p_hot & cell_valid & next_vec);
    assign merge_prev = |(pm1_hot & end_vec);
    assign fit_exact  = |(fit_hot & eq_vec);

    // Choose the table update and the status from the compare results.
    always_comb begin
        act_next        = ACT_NONE;
        tgt_next        = '0;
        span_next       = '0;
        res_status_next = STATUS_OK;
        if (cmd_reg == CMD_ALLOC) begin
            if ((len_reg == '0) || (fit_hot == '0)) begin
                res_status_next = STATUS_NOFIT;
            end else if (fit_exact) begin
                act_next  = ACT_REMOVE;
                tgt_next  = fit_hot;
                span_next = fit_ge;
            end else begin
                act_next = ACT_SHRINK;
                tgt_next = fit_hot;
            end
        end else if (len_reg != '0) begin
            priority if (merge_prev && merge_next) begin
                act_next  = ACT_JOIN;
                tgt_next  = pm1_hot;
                span_next = p_ge;
            end else if (merge_prev) begin
                act_next = ACT_GROW_PREV;
                tgt_next = pm1_hot;
            end else if (merge_next) begin
                act_next = ACT_GROW_NEXT;
                tgt_next = p_hot;
            end else if (cell_valid[N-1]) begin
                res_status_next = STATUS_FULL;
            end else begin
                act_next  = ACT_INSERT;
                tgt_next  = p_hot;
                span_next = p_ge & ~p_hot;
            end
        end
    end

    // Start of the target entry, read before the update.
    always_comb begin
        granted_any = '0;
        for (int i = 0; i < N; i++) begin
            granted_any = granted_any | (cell_start[i] & {ADDR_W{tgt_reg[i]}});
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl.cmp_en = 1'b0;
        ctl.exe_en = 1'b0;
        ctl.act    = act_reg;
        load_req   = 1'b0;
        load_sel   = 1'b0;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    load_req   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctl.cmp_en = 1'b1;
                state_next = S_SEL;
            end
            S_SEL: begin
                load_sel   = 1'b1;
                state_next = S_EXE;
            end
            S_EXE: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.exe_en = 1'b1;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Request and decision registers.
    always_ff @(posedge aclk) begin
        if (load_req) begin
            cmd_reg  <= s_command;
            addr_reg <= ADDR_W'(s_address);
            len_reg  <= s_length;
        end
        if (load_sel) begin
            res_status_reg <= res_status_next;
            tgt_reg        <= tgt_next;
            span_reg       <= span_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= ACT_NONE;
        end else if (load_sel) begin
            act_reg <= act_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg <= res_status_reg;
            if ((act_reg == ACT_SHRINK) || (act_reg == ACT_REMOVE)) begin
                m_granted_reg <= ADDR_IN_W'(granted_any);
            end else begin
                m_granted_reg <= '0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_granted_reg;

endmodule

>>> sv/ffra_checker.sv
`include "first_fit_region_allocator_core_macros.svh"

module ffra_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [ffra_pkg::STATUS_W-1:0]   m_status,
    input logic [ffra_pkg::ADDR_IN_W-1:0]  m_granted_address
);
    import ffra_pkg::*;

    // A result with a status other than OK never carries an address.
    `FFRA_ASSERT_NOW(a_fail_no_addr, aclk, aresetn, m_valid && (m_status != STATUS_OK), m_granted_address == '0)

    // A stalled result holds.
    `FFRA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_granted_address))

    // The block takes no new item while one is being worked on.
    `FFRA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready ##1 !s_ready ##1 !s_ready)

    // A new result is checked against the acceptance of its item.
    `FFRA_ASSERT_NOW(a_result_timing, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready, 4))

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);

>>> tb/tb_first_fit_region_allocator_core.sv
`timescale 1ns / 100ps

module tb_first_fit_region_allocator_core;
    import ffra_pkg::*;

    localparam int ENTRIES       = DEF_TABLE_ENTRIES;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASES        = 8;
    localparam int DRAIN_CYCLES  = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int STEP_COUNT    = 20;

    // One result item as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_IN_W-1:0] granted;
    } grant_t;

    // A region handed out by the block and not yet returned.
    typedef struct packed {
        logic [ADDR_IN_W-1:0] base;
        logic [LEN_W-1:0]     size;
    } block_t;

    // One row of the directed sequence; known rows carry their own answer.
    typedef struct packed {
        logic                 command;
        logic [ADDR_IN_W-1:0] address;
        logic [LEN_W-1:0]     length;
        logic                 known;
        logic [STATUS_W-1:0]  status;
        logic [ADDR_IN_W-1:0] granted;
    } step_t;

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic                 s_command         = CMD_ALLOC;
    logic [ADDR_IN_W-1:0] s_address         = '0;
    logic [LEN_W-1:0]     s_length          = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [ADDR_IN_W-1:0] m_granted_address;

    // Shadow copy of the free table.
    logic [ADDR_IN_W-1:0] free_start [ENTRIES];
    logic [LEN_W-1:0]     free_len   [ENTRIES];
    int                   free_count;

    grant_t expected_grants [$];
    block_t held_blocks [$];
    int     mismatch_count = 0;
    int     idle_pct       = 0;
    int     stall_pct      = 0;

    // Directed sequence, starting from the table loaded at reset.
    step_t directed_steps [STEP_COUNT] = '{
        // Zero-length requests change nothing.
        '{CMD_ALLOC, 16'd0,     17'd0,     1'b1, STATUS_NOFIT, 16'd0},
        '{CMD_FREE,  16'd0,     17'd0,     1'b1, STATUS_OK,    16'd0},
        // Longest request does not fit anywhere.
        '{CMD_ALLOC, 16'd0,     17'd65536, 1'b1, STATUS_NOFIT, 16'd0},
        // Exact fits remove both reset regions; the address is ignored.
        '{CMD_ALLOC, 16'hFFFF,  17'd12,    1'b1, STATUS_OK,    16'd14},
        '{CMD_ALLOC, 16'd0,     17'd96,    1'b1, STATUS_OK,    16'd32},
        // Allocate from an empty table.
        '{CMD_ALLOC, 16'd0,     17'd1,     1'b1, STATUS_NOFIT, 16'd0},
        // Free into an empty table, a region reaching past the top.
        '{CMD_FREE,  16'hFFFF,  17'd65536, 1'b1, STATUS_OK,    16'd0},
        '{CMD_FREE,  16'd0,     17'd10,    1'b1, STATUS_OK,    16'd0},
        // Partial allocate whose new start wraps around.
        '{CMD_ALLOC, 16'd0,     17'd100,   1'b0, STATUS_OK,    16'd0},
        // Free joining both neighbors, then growing to the widest length.
        '{CMD_FREE,  16'd10,    17'd89,    1'b0, STATUS_OK,    16'd0},
        '{CMD_FREE,  16'hFFFF,  17'd65536, 1'b0, STATUS_OK,    16'd0},
        '{CMD_ALLOC, 16'd0,     17'd65536, 1'b0, STATUS_OK,    16'd0},
        '{CMD_ALLOC, 16'd0,     17'd65535, 1'b0, STATUS_OK,    16'd0},
        // Insert, grow the previous, grow the next, insert, join.
        '{CMD_FREE,  16'd100,   17'd50,    1'b0, STATUS_OK,    16'd0},
        '{CMD_FREE,  16'd150,   17'd10,    1'b0, STATUS_OK,    16'd0},
        '{CMD_FREE,  16'd90,    17'd10,    1'b0, STATUS_OK,    16'd0},
        '{CMD_FREE,  16'd300,   17'd20,    1'b0, STATUS_OK,    16'd0},
        '{CMD_FREE,  16'd160,   17'd140,   1'b0, STATUS_OK,    16'd0},
        '{CMD_ALLOC, 16'd0,     17'd20,    1'b0, STATUS_OK,    16'd0},
        // Region ending exactly at the top of the address space.
        '{CMD_FREE,  16'hFFF0,  17'd16,    1'b0, STATUS_OK,    16'd0}
    };

    first_fit_region_allocator_core u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_address         (s_address),
        .s_length          (s_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Lengths sum without wrap and stop at the largest length.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W+1:0] sum);
        return (sum > {2'b00, {LEN_W{1'b1}}}) ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    endfunction

    // Removes one entry and closes the gap.
    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < free_count; i++) begin
            free_start[i] = free_start[i + 1];
            free_len[i]   = free_len[i + 1];
        end
        free_count--;
        free_start[free_count] = '0;
        free_len[free_count]   = '0;
    endfunction

    // Applies one item to the shadow table and returns the result it causes.
    function automatic grant_t compute_grant(input logic cmd,
                                             input logic [ADDR_IN_W-1:0] addr,
                                             input logic [LEN_W-1:0] len);
        grant_t res;
        int     pos;
        logic   taken;
        logic   join_next;
        logic   join_prev;
        res.status  = STATUS_OK;
        res.granted = '0;
        if (cmd == CMD_ALLOC) begin
            // First fit: shrink from the low end, or remove on an exact fit.
            res.status = STATUS_NOFIT;
            taken = 1'b0;
            if (len != '0) begin
                for (int i = 0; i < free_count && !taken; i++) begin
                    if (free_len[i] >= len) begin
                        taken       = 1'b1;
                        res.status  = STATUS_OK;
                        res.granted = free_start[i];
                        if (free_len[i] > len) begin
                            free_start[i] = free_start[i] + len[ADDR_IN_W-1:0];
                            free_len[i]   = free_len[i] - len;
                        end else begin
                            drop_entry(i);
                        end
                    end
                end
            end
        end else if (len != '0) begin
            // Place in front of the first entry starting above the address.
            pos = 0;
            while (pos < free_count && free_start[pos] <= addr) pos++;
            join_next = 1'b0;
            join_prev = 1'b0;
            if (pos < free_count)
                join_next = ({2'b00, addr} + {1'b0, len}) == {2'b00, free_start[pos]};
            if (pos > 0)
                join_prev = ({2'b00, free_start[pos-1]} + {1'b0, free_len[pos-1]})
                            == {2'b00, addr};
            if (join_prev && join_next) begin
                free_len[pos-1] = clamp_len({1'b0, clamp_len({2'b00, free_len[pos-1]}
                                  + {2'b00, len})} + {2'b00, free_len[pos]});
                drop_entry(pos);
            end else if (join_prev) begin
                free_len[pos-1] = clamp_len({2'b00, free_len[pos-1]} + {2'b00, len});
            end else if (join_next) begin
                free_start[pos] = addr;
                free_len[pos]   = clamp_len({2'b00, free_len[pos]} + {2'b00, len});
            end else if (free_count >= ENTRIES) begin
                res.status = STATUS_FULL;
            end else begin
                for (int i = free_count; i > pos; i--) begin
                    free_start[i] = free_start[i - 1];
                    free_len[i]   = free_len[i - 1];
                end
                free_start[pos] = addr;
                free_len[pos]   = len;
                free_count++;
            end
        end
        return res;
    endfunction

    // Presents one item, waits for it to be taken, and records its result.
    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(input logic cmd, input logic [ADDR_IN_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic known,
                             input grant_t typed);
        grant_t predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_address <= addr;
        s_length  <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = compute_grant(cmd, addr, len);
        expected_grants = {expected_grants, (known ? typed : predicted)};
        if (cmd == CMD_ALLOC && predicted.status == STATUS_OK)
            held_blocks = {held_blocks, block_t'{predicted.granted, len}};
        @(negedge aclk);
    endtask

    // Random item: mostly allocations and returns of granted regions,
    // with frees next to existing regions and some unrelated traffic.
    task automatic send_random_item();
        logic                 cmd;
        logic [ADDR_IN_W-1:0] addr;
        logic [LEN_W-1:0]     len;
        int                   pick;
        int                   idx;
        block_t               blk;
        pick = $urandom_range(0, 99);
        cmd  = CMD_ALLOC;
        addr = ADDR_IN_W'($urandom);
        len  = LEN_W'($urandom_range(1, 64));
        if (pick < 30) begin
            if ($urandom_range(0, 3) == 0) len = LEN_W'($urandom_range(1, 4096));
        end else if (pick < 40) begin
            // Ask for the exact size of some region.
            if (free_count > 0) begin
                len = free_len[$urandom_range(0, free_count - 1)];
                if (len > LEN_W'(65536)) len = LEN_W'(65536);
            end
        end else if (pick < 65) begin
            cmd = CMD_FREE;
            if (held_blocks.size() > 0) begin
                idx  = $urandom_range(0, held_blocks.size() - 1);
                blk  = held_blocks[idx];
                held_blocks.delete(idx);
                addr = blk.base;
                len  = blk.size;
            end
        end else if (pick < 75) begin
            // Free right after or right before an existing region.
            cmd = CMD_FREE;
            if (free_count > 0) begin
                idx = $urandom_range(0, free_count - 1);
                if ($urandom_range(0, 1) == 0)
                    addr = free_start[idx] + free_len[idx][ADDR_IN_W-1:0];
                else
                    addr = free_start[idx] - len[ADDR_IN_W-1:0];
            end
        end else if (pick < 90) begin
            cmd = CMD_FREE;
            len = LEN_W'($urandom_range(1, 256));
        end else if (pick < 96) begin
            cmd = 1'($urandom_range(0, 1));
            len = LEN_W'($urandom_range(0, 65536));
        end else begin
            cmd = 1'($urandom_range(0, 1));
            len = '0;
        end
        send_item(cmd, addr, len, 1'b0, '0);
    endtask

    // Holds the input idle until every expected result has come back or the drain limit is reached.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_grants.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        @(negedge aclk);
    endtask

    // Result side: random stalls, changed at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch("result item with nothing outstanding");
            end else begin
                want = expected_grants.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, want.status));
                if (m_granted_address !== want.granted)
                    report_mismatch($sformatf("granted address %0d, expected %0d",
                                              m_granted_address, want.granted));
            end
        end
    end

    // Main sequence.
    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            free_start[i] = '0;
            free_len[i]   = '0;
        end
        free_start[0] = ADDR_IN_W'(RST_START_A);
        free_len[0]   = LEN_W'(RST_LENGTH_A);
        free_start[1] = ADDR_IN_W'(RST_START_B);
        free_len[1]   = LEN_W'(RST_LENGTH_B);
        free_count    = 2;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_steps[i]) begin
            send_item(directed_steps[i].command, directed_steps[i].address,
                      directed_steps[i].length, directed_steps[i].known,
                      grant_t'{directed_steps[i].status, directed_steps[i].granted});
        end
        wait_for_results();

        // Random phases with different idling on each side.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default: begin
                    idle_pct  = 21;
                    stall_pct = 21;
                end
            endcase
            repeat (RANDOM_ITEMS / PHASES) send_random_item();
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_grants.size() != 0)
            report_mismatch($sformatf("%0d result items never arrived",
                                      expected_grants.size()));
        if (mismatch_count == 0)
            $display("[first_fit_region_allocator_core] OK");
        else
            $display("[first_fit_region_allocator_core] ERROR");
        $finish;
    end

    // Hang guard.
    initial begin
        #5_000_000;
        $display("[first_fit_region_allocator_core] ERROR");
        $finish;
    end

endmodule
